[rtl/core/hsvc_pkg.sv]
// shared types and constants for the hsv to rgb converter
`default_nettype none

package hsvc_pkg;

    // input moduli and scale factors
    localparam int unsigned HUE_MOD    = 361;
    localparam int unsigned PCT_MOD    = 101;
    localparam int unsigned HUE_TOP    = 360;
    localparam int unsigned SECTOR_DEG = 60;
    localparam int unsigned PCT_SCALE  = 100;
    localparam int unsigned RAMP_SCALE = 6000;

    // exact reciprocals: floor(x/d) = (x * ceil(2^k/d)) >> k for every x in range
    localparam int unsigned HUE_SHIFT = 25;
    localparam logic [16:0] HUE_RECIP =
        17'((64'd1 << HUE_SHIFT) / 64'(HUE_MOD) + 64'd1);
    localparam int unsigned PCT_SHIFT = 23;
    localparam logic [16:0] PCT_RECIP =
        17'((64'd1 << PCT_SHIFT) / 64'(PCT_MOD) + 64'd1);

    // divisors of the level equations
    localparam int unsigned FULL_SHIFT = 22;
    localparam logic [15:0] FULL_RECIP =
        16'(((64'd1 << FULL_SHIFT) + 64'd99) / 64'd100);
    localparam int unsigned P_SHIFT = 36;
    localparam logic [22:0] P_RECIP =
        23'(((64'd1 << P_SHIFT) + 64'd9999) / 64'd10000);
    localparam int unsigned QT_SHIFT = 48;
    localparam logic [28:0] QT_RECIP =
        29'(((64'd1 << QT_SHIFT) + 64'd599999) / 64'd600000);

    typedef logic [8:0] hue_t;
    typedef logic [6:0] pct_t;
    typedef logic [7:0] chan_t;

    typedef enum logic [2:0] {
        SECTOR_R_Y = 3'd0,
        SECTOR_Y_G = 3'd1,
        SECTOR_G_C = 3'd2,
        SECTOR_C_B = 3'd3,
        SECTOR_B_M = 3'd4,
        SECTOR_M_R = 3'd5
    } sector_t;

    typedef struct packed {
        hue_t hue;
        pct_t sat;
        pct_t val;
    } hsv_t;

    typedef struct packed {
        sector_t     sector;
        pct_t        val;
        logic [19:0] num_q;
        logic [19:0] num_t;
        logic [13:0] num_p;
    } ramp_t;

    typedef struct packed {
        sector_t sector;
        chan_t   full;
        chan_t   lvl_q;
        chan_t   lvl_t;
        chan_t   lvl_p;
    } level_t;

endpackage

`default_nettype wire

[rtl/core/hsvc_reduce.sv]
// two-stage modulo reduction of raw hue, saturation and value
`default_nettype none

module hsvc_reduce (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [15:0]     hue_raw,
    input  logic [15:0]     sat_raw,
    input  logic [15:0]     val_raw,
    output logic            out_valid,
    input  logic            out_ready,
    output hsvc_pkg::hsv_t  out_data
);

    logic              vld1_reg;
    logic              vld2_reg;
    logic              ready1;
    logic              ready2;
    logic [15:0]       hue_raw_reg;
    logic [15:0]       sat_raw_reg;
    logic [15:0]       val_raw_reg;
    logic [7:0]        hue_quo_reg;
    logic [9:0]        sat_quo_reg;
    logic [9:0]        val_quo_reg;
    logic [32:0]       hue_prod;
    logic [32:0]       sat_prod;
    logic [32:0]       val_prod;
    logic [15:0]       hue_back;
    logic [15:0]       sat_back;
    logic [15:0]       val_back;
    logic [15:0]       hue_rem;
    logic [15:0]       sat_rem;
    logic [15:0]       val_rem;
    hsvc_pkg::hsv_t    hsv_reg;

    assign ready2   = !vld2_reg || out_ready;
    assign ready1   = !vld1_reg || ready2;
    assign in_ready = ready1;

    // quotient by reciprocal multiply
    assign hue_prod = 33'(hue_raw) * 33'(hsvc_pkg::HUE_RECIP);
    assign sat_prod = 33'(sat_raw) * 33'(hsvc_pkg::PCT_RECIP);
    assign val_prod = 33'(val_raw) * 33'(hsvc_pkg::PCT_RECIP);

    // remainder from registered quotient
    assign hue_back = 16'(hue_quo_reg) * 16'(hsvc_pkg::HUE_MOD);
    assign sat_back = 16'(sat_quo_reg) * 16'(hsvc_pkg::PCT_MOD);
    assign val_back = 16'(val_quo_reg) * 16'(hsvc_pkg::PCT_MOD);
    assign hue_rem  = hue_raw_reg - hue_back;
    assign sat_rem  = sat_raw_reg - sat_back;
    assign val_rem  = val_raw_reg - val_back;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                vld1_reg <= in_valid;
            end
            if (ready2)
            begin
                vld2_reg <= vld1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && in_valid)
        begin
            hue_raw_reg <= hue_raw;
            sat_raw_reg <= sat_raw;
            val_raw_reg <= val_raw;
            hue_quo_reg <= hue_prod[hsvc_pkg::HUE_SHIFT +: 8];
            sat_quo_reg <= sat_prod[hsvc_pkg::PCT_SHIFT +: 10];
            val_quo_reg <= val_prod[hsvc_pkg::PCT_SHIFT +: 10];
        end
        if (ready2 && vld1_reg)
        begin
            hsv_reg.hue <= hue_rem[8:0];
            hsv_reg.sat <= sat_rem[6:0];
            hsv_reg.val <= val_rem[6:0];
        end
    end

    assign out_valid = vld2_reg;
    assign out_data  = hsv_reg;

endmodule

`default_nettype wire

[rtl/core/hsvc_sector.sv]
// sector split and ramp numerators over three stages
`default_nettype none

module hsvc_sector (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  hsvc_pkg::hsv_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output hsvc_pkg::ramp_t out_data
);

    logic                 vld3_reg;
    logic                 vld4_reg;
    logic                 vld5_reg;
    logic                 ready3;
    logic                 ready4;
    logic                 ready5;
    hsvc_pkg::sector_t    sector_next;
    logic [5:0]           hm_next;
    hsvc_pkg::sector_t    sector3_reg;
    logic [5:0]           hm3_reg;
    hsvc_pkg::pct_t       sat3_reg;
    hsvc_pkg::pct_t       val3_reg;
    hsvc_pkg::sector_t    sector4_reg;
    hsvc_pkg::pct_t       val4_reg;
    logic [12:0]          hs_q4_reg;
    logic [12:0]          hs_t4_reg;
    hsvc_pkg::pct_t       np4_reg;
    logic [5:0]           hm_rev;
    logic [12:0]          nq;
    logic [12:0]          nt;
    hsvc_pkg::ramp_t      ramp_reg;

    assign ready5   = !vld5_reg || out_ready;
    assign ready4   = !vld4_reg || ready5;
    assign ready3   = !vld3_reg || ready4;
    assign in_ready = ready3;

    // hue of 360 folds back to the start of the red sector
    always_comb
    begin
        priority if (in_data.hue >= 9'(hsvc_pkg::HUE_TOP))
        begin
            sector_next = hsvc_pkg::SECTOR_R_Y;
            hm_next     = 6'd0;
        end
        else if (in_data.hue >= 9'(5 * hsvc_pkg::SECTOR_DEG))
        begin
            sector_next = hsvc_pkg::SECTOR_M_R;
            hm_next     = 6'(in_data.hue - 9'(5 * hsvc_pkg::SECTOR_DEG));
        end
        else if (in_data.hue >= 9'(4 * hsvc_pkg::SECTOR_DEG))
        begin
            sector_next = hsvc_pkg::SECTOR_B_M;
            hm_next     = 6'(in_data.hue - 9'(4 * hsvc_pkg::SECTOR_DEG));
        end
        else if (in_data.hue >= 9'(3 * hsvc_pkg::SECTOR_DEG))
        begin
            sector_next = hsvc_pkg::SECTOR_C_B;
            hm_next     = 6'(in_data.hue - 9'(3 * hsvc_pkg::SECTOR_DEG));
        end
        else if (in_data.hue >= 9'(2 * hsvc_pkg::SECTOR_DEG))
        begin
            sector_next = hsvc_pkg::SECTOR_G_C;
            hm_next     = 6'(in_data.hue - 9'(2 * hsvc_pkg::SECTOR_DEG));
        end
        else if (in_data.hue >= 9'(hsvc_pkg::SECTOR_DEG))
        begin
            sector_next = hsvc_pkg::SECTOR_Y_G;
            hm_next     = 6'(in_data.hue - 9'(hsvc_pkg::SECTOR_DEG));
        end
        else
        begin
            sector_next = hsvc_pkg::SECTOR_R_Y;
            hm_next     = in_data.hue[5:0];
        end
    end

    assign hm_rev = 6'(hsvc_pkg::SECTOR_DEG) - hm3_reg;
    assign nq     = 13'(hsvc_pkg::RAMP_SCALE) - hs_q4_reg;
    assign nt     = 13'(hsvc_pkg::RAMP_SCALE) - hs_t4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            if (ready3)
            begin
                vld3_reg <= in_valid;
            end
            if (ready4)
            begin
                vld4_reg <= vld3_reg;
            end
            if (ready5)
            begin
                vld5_reg <= vld4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && in_valid)
        begin
            sector3_reg <= sector_next;
            hm3_reg     <= hm_next;
            sat3_reg    <= in_data.sat;
            val3_reg    <= in_data.val;
        end
        if (ready4 && vld3_reg)
        begin
            sector4_reg <= sector3_reg;
            val4_reg    <= val3_reg;
            hs_q4_reg   <= 13'(hm3_reg) * 13'(sat3_reg);
            hs_t4_reg   <= 13'(hm_rev) * 13'(sat3_reg);
            np4_reg     <= 7'(hsvc_pkg::PCT_SCALE) - sat3_reg;
        end
        if (ready5 && vld4_reg)
        begin
            ramp_reg.sector <= sector4_reg;
            ramp_reg.val    <= val4_reg;
            ramp_reg.num_q  <= 20'(val4_reg) * 20'(nq);
            ramp_reg.num_t  <= 20'(val4_reg) * 20'(nt);
            ramp_reg.num_p  <= 14'(val4_reg) * 14'(np4_reg);
        end
    end

    assign out_valid = vld5_reg;
    assign out_data  = ramp_reg;

endmodule

`default_nettype wire

[rtl/core/hsvc_level.sv]
// scale by 255 and divide by constants through exact reciprocals
`default_nettype none

module hsvc_level (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hsvc_pkg::ramp_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output hsvc_pkg::level_t out_data
);

    logic              vld6_reg;
    logic              ready6;
    logic [14:0]       x_full;
    logic [27:0]       x_q;
    logic [27:0]       x_t;
    logic [21:0]       x_p;
    logic [30:0]       prod_full;
    logic [56:0]       prod_q;
    logic [56:0]       prod_t;
    logic [44:0]       prod_p;
    hsvc_pkg::level_t  level_reg;

    assign ready6   = !vld6_reg || out_ready;
    assign in_ready = ready6;

    // times 255 as shift and subtract
    assign x_full = (15'(in_data.val) << 8) - 15'(in_data.val);
    assign x_q    = (28'(in_data.num_q) << 8) - 28'(in_data.num_q);
    assign x_t    = (28'(in_data.num_t) << 8) - 28'(in_data.num_t);
    assign x_p    = (22'(in_data.num_p) << 8) - 22'(in_data.num_p);

    assign prod_full = 31'(x_full) * 31'(hsvc_pkg::FULL_RECIP);
    assign prod_q    = 57'(x_q) * 57'(hsvc_pkg::QT_RECIP);
    assign prod_t    = 57'(x_t) * 57'(hsvc_pkg::QT_RECIP);
    assign prod_p    = 45'(x_p) * 45'(hsvc_pkg::P_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld6_reg <= 1'b0;
        end
        else if (ready6)
        begin
            vld6_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready6 && in_valid)
        begin
            level_reg.sector <= in_data.sector;
            level_reg.full   <= prod_full[hsvc_pkg::FULL_SHIFT +: 8];
            level_reg.lvl_q  <= prod_q[hsvc_pkg::QT_SHIFT +: 8];
            level_reg.lvl_t  <= prod_t[hsvc_pkg::QT_SHIFT +: 8];
            level_reg.lvl_p  <= prod_p[hsvc_pkg::P_SHIFT +: 8];
        end
    end

    assign out_valid = vld6_reg;
    assign out_data  = level_reg;

endmodule

`default_nettype wire

[rtl/core/hsv_to_rgb_converter.sv]
// top level of the hsv to rgb converter: pipeline and channel select
// throughput: one word per cycle while out_ready is high; a stall only backs up the stages that hold words
// in_ready drops only when every one of the seven stages holds a word and out_ready is low
// reset: rst_n asynchronous active low clears every stage valid bit, pipeline empty
`default_nettype none

module hsv_to_rgb_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] hue_raw,
    input  logic [15:0] sat_raw,
    input  logic [15:0] val_raw,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    // stage map
    //   1-2  hsvc_reduce  reciprocal quotient, then remainder (hue mod 361, s/v mod 101)
    //   3-5  hsvc_sector  sector and offset, offset times sat, ramp numerators times val
    //   6    hsvc_level   times 255, divide by 100 / 10000 / 600000 via exact reciprocals
    //   7    here         pick full, p, q, t per sector into the output register
    // every stage holds a valid bit and moves when it is empty or the next one moves

    logic               hsv_valid;
    logic               hsv_ready;
    hsvc_pkg::hsv_t     hsv_data;
    logic               ramp_valid;
    logic               ramp_ready;
    hsvc_pkg::ramp_t    ramp_data;
    logic               lvl_valid;
    logic               lvl_ready;
    hsvc_pkg::level_t   lvl_data;

    logic               out_vld_reg;
    hsvc_pkg::chan_t    red_reg;
    hsvc_pkg::chan_t    green_reg;
    hsvc_pkg::chan_t    blue_reg;
    hsvc_pkg::chan_t    red_next;
    hsvc_pkg::chan_t    green_next;
    hsvc_pkg::chan_t    blue_next;

    hsvc_reduce u_reduce (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .hue_raw   (hue_raw),
        .sat_raw   (sat_raw),
        .val_raw   (val_raw),
        .out_valid (hsv_valid),
        .out_ready (hsv_ready),
        .out_data  (hsv_data)
    );

    hsvc_sector u_sector (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (hsv_valid),
        .in_ready  (hsv_ready),
        .in_data   (hsv_data),
        .out_valid (ramp_valid),
        .out_ready (ramp_ready),
        .out_data  (ramp_data)
    );

    hsvc_level u_level (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ramp_valid),
        .in_ready  (ramp_ready),
        .in_data   (ramp_data),
        .out_valid (lvl_valid),
        .out_ready (lvl_ready),
        .out_data  (lvl_data)
    );

    // output register takes a word whenever it is empty or being drained
    assign lvl_ready = !out_vld_reg || out_ready;

    // zero saturation needs no special path: p, q and t all reduce to the full level
    always_comb
    begin
        unique case (lvl_data.sector)
            hsvc_pkg::SECTOR_R_Y:
            begin
                red_next   = lvl_data.full;
                green_next = lvl_data.lvl_t;
                blue_next  = lvl_data.lvl_p;
            end
            hsvc_pkg::SECTOR_Y_G:
            begin
                red_next   = lvl_data.lvl_q;
                green_next = lvl_data.full;
                blue_next  = lvl_data.lvl_p;
            end
            hsvc_pkg::SECTOR_G_C:
            begin
                red_next   = lvl_data.lvl_p;
                green_next = lvl_data.full;
                blue_next  = lvl_data.lvl_t;
            end
            hsvc_pkg::SECTOR_C_B:
            begin
                red_next   = lvl_data.lvl_p;
                green_next = lvl_data.lvl_q;
                blue_next  = lvl_data.full;
            end
            hsvc_pkg::SECTOR_B_M:
            begin
                red_next   = lvl_data.lvl_t;
                green_next = lvl_data.lvl_p;
                blue_next  = lvl_data.full;
            end
            hsvc_pkg::SECTOR_M_R:
            begin
                red_next   = lvl_data.full;
                green_next = lvl_data.lvl_p;
                blue_next  = lvl_data.lvl_q;
            end
            default:
            begin
                red_next   = lvl_data.full;
                green_next = lvl_data.lvl_t;
                blue_next  = lvl_data.lvl_p;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (lvl_ready)
        begin
            out_vld_reg <= lvl_valid;
        end
    end

    // payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (lvl_ready && lvl_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

`default_nettype wire

[rtl/core/hsvc_checker.sv]
// port-level checker for the hsv to rgb converter and its bind
`default_nettype none

module hsvc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [15:0] hue_raw,
    input logic [15:0] sat_raw,
    input logic [15:0] val_raw,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue
);

    // a held output word stays
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // a held output word keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
        else $error("output word changed while stalled");

    // a draining output frees every stage, so the input side must be open
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input blocked while output drains");

    // an empty output register always leaves room upstream
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // a waiting input word stays offered with the same payload
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(hue_raw) && $stable(sat_raw)
            && $stable(val_raw))
        else $error("input word changed while waiting");

endmodule

bind hsv_to_rgb_converter hsvc_checker u_hsvc_checker (.*);

`default_nettype wire
